/* rtl/pqkr_pkg.sv */
package pqkr_pkg;

   localparam int POOL_SLOTS   = 16;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 32;

   localparam int SLOT_BITS = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(POOL_SLOTS + 1);
   localparam int CAP_BITS  = 5;
   localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   localparam int ACTION_W  = 2;
   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int OCC_W     = 5;

   localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [KEY_W-1:0]     item_key;
      logic [PAYLOAD_W-1:0] item_payload;
   } req_word_type;

   typedef struct packed {
      logic                 status;
      logic [KEY_W-1:0]     out_key;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [OCC_W-1:0]     occupancy;
      logic                 is_empty;
      logic                 is_full;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic scan_next;
      logic enq_write;
      logic enq_tail;
      logic deq_take;
      logic walk_next;
      logic rem_unlink;
   } cmd_type;

   typedef struct packed {
      logic cap_zero;
      logic cnt_zero;
      logic full;
      logic slot_free;
      logic key_match;
      logic at_tail;
   } stat_type;

endpackage

/* rtl/pqkr_ctrl.sv */
module pqkr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pqkr_pkg::ACTION_W-1:0] action,
   input  pqkr_pkg::stat_type            stat,
   output pqkr_pkg::cmd_type             cmd,
   output logic                          busy,
   output logic                          rsp_strobe
);
   import pqkr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ENQ_TAIL,
      ST_DEQ,
      ST_WALK,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_strobe_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               unique case (action)
                  ACT_ENQUEUE: state_in = stat.full ? ST_RESP : ST_SCAN;
                  ACT_DEQUEUE: state_in = (stat.cap_zero || stat.cnt_zero) ? ST_RESP : ST_DEQ;
                  ACT_REMOVE:  state_in = (stat.cap_zero || stat.cnt_zero) ? ST_RESP : ST_WALK;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.slot_free) begin
               cmd.enq_write = 1'b1;
               state_in      = ST_ENQ_TAIL;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_ENQ_TAIL: begin
            cmd.enq_tail = 1'b1;
            state_in     = ST_RESP;
         end
         ST_DEQ: begin
            cmd.deq_take = 1'b1;
            state_in     = ST_RESP;
         end
         ST_WALK: begin
            if (stat.key_match) begin
               cmd.rem_unlink = 1'b1;
               state_in       = ST_RESP;
            end else if (stat.at_tail) begin
               state_in = ST_RESP;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= (state_in != ST_IDLE);
         rsp_strobe_ff <= (state_in == ST_RESP);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

/* rtl/pqkr_dpath.sv */
module pqkr_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [pqkr_pkg::CAP_BITS-1:0] csr_wr_data,
   input  pqkr_pkg::req_word_type        req_word,
   input  pqkr_pkg::cmd_type             cmd,
   output pqkr_pkg::stat_type            stat,
   output pqkr_pkg::rsp_word_type        rsp_word
);
   import pqkr_pkg::*;

   logic [KEY_BITS-1:0]     key_mem     [POOL_SLOTS];
   logic [PAYLOAD_BITS-1:0] payload_mem [POOL_SLOTS];
   logic [SLOT_BITS-1:0]    link_ff     [POOL_SLOTS];

   logic [CAP_BITS-1:0]     cap_ff;
   logic [POOL_SLOTS-1:0]   used_ff, used_in;
   logic [SLOT_BITS-1:0]    head_ff, head_in;
   logic [SLOT_BITS-1:0]    tail_ff, tail_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;

   logic [KEY_BITS-1:0]     req_key_ff;
   logic [PAYLOAD_BITS-1:0] req_payload_ff;
   logic [KEY_BITS-1:0]     rd_key_ff;
   logic [PAYLOAD_BITS-1:0] rd_payload_ff;
   logic [KEY_BITS-1:0]     out_key_ff;
   logic [PAYLOAD_BITS-1:0] out_payload_ff;
   logic                    fail_ff;
   logic [SLOT_BITS-1:0]    scan_ff;
   logic [SLOT_BITS-1:0]    cur_ff;
   logic [SLOT_BITS-1:0]    prev_ff;
   logic                    first_ff;

   logic [SLOT_BITS-1:0]    rd_addr;
   logic                    link_we;
   logic [SLOT_BITS-1:0]    link_waddr;
   logic [SLOT_BITS-1:0]    link_wdata;
   logic [CMP_BITS-1:0]     cap_ext;
   logic [CMP_BITS-1:0]     eff_cap;

   assign cap_ext = CMP_BITS'(cap_ff);
   assign eff_cap = (cap_ext > CMP_BITS'(POOL_SLOTS)) ? CMP_BITS'(POOL_SLOTS) : cap_ext;

   assign stat.cap_zero  = (cap_ff == '0);
   assign stat.cnt_zero  = (count_ff == '0);
   assign stat.full      = (CMP_BITS'(count_ff) >= eff_cap);
   assign stat.slot_free = !used_ff[scan_ff];
   assign stat.key_match = (rd_key_ff == req_key_ff);
   assign stat.at_tail   = (cur_ff == tail_ff);

   assign rd_addr = cmd.walk_next ? link_ff[cur_ff] : head_ff;

   always_comb begin
      used_in    = used_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      link_we    = 1'b0;
      link_waddr = scan_ff;
      link_wdata = scan_ff;
      if (cmd.enq_write) begin
         used_in[scan_ff] = 1'b1;
         count_in         = count_ff + CNT_BITS'(1);
         link_we          = 1'b1;
         link_waddr       = stat.cnt_zero ? scan_ff : tail_ff;
         if (stat.cnt_zero) begin
            head_in = scan_ff;
         end
      end
      if (cmd.enq_tail) begin
         link_we = 1'b1;
         tail_in = scan_ff;
      end
      if (cmd.deq_take) begin
         used_in[head_ff] = 1'b0;
         count_in         = count_ff - CNT_BITS'(1);
         head_in          = link_ff[head_ff];
      end
      if (cmd.rem_unlink) begin
         used_in[cur_ff] = 1'b0;
         count_in        = count_ff - CNT_BITS'(1);
         if (first_ff) begin
            head_in = link_ff[head_ff];
         end else begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            if (stat.at_tail) begin
               link_wdata = prev_ff;
               tail_in    = prev_ff;
            end else begin
               link_wdata = link_ff[cur_ff];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= '0;
         used_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (csr_wr_en && stat.cap_zero) begin
         cap_ff   <= csr_wr_data;
         used_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_ff[link_waddr] <= link_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enq_write) begin
         key_mem[scan_ff]     <= req_key_ff;
         payload_mem[scan_ff] <= req_payload_ff;
      end
      rd_key_ff     <= key_mem[rd_addr];
      rd_payload_ff <= payload_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_key_ff     <= KEY_BITS'(req_word.item_key);
         req_payload_ff <= PAYLOAD_BITS'(req_word.item_payload);
         out_key_ff     <= '0;
         out_payload_ff <= '0;
         fail_ff        <= 1'b1;
         scan_ff        <= '0;
         cur_ff         <= head_ff;
         first_ff       <= 1'b1;
      end else begin
         if (cmd.scan_next) begin
            scan_ff <= scan_ff + SLOT_BITS'(1);
         end
         if (cmd.walk_next) begin
            prev_ff  <= cur_ff;
            cur_ff   <= link_ff[cur_ff];
            first_ff <= 1'b0;
         end
         if (cmd.deq_take) begin
            out_key_ff     <= rd_key_ff;
            out_payload_ff <= rd_payload_ff;
         end
         if (cmd.enq_tail || cmd.deq_take || cmd.rem_unlink) begin
            fail_ff <= 1'b0;
         end
      end
   end

   assign rsp_word.status      = fail_ff;
   assign rsp_word.out_key     = KEY_W'(out_key_ff);
   assign rsp_word.out_payload = PAYLOAD_W'(out_payload_ff);
   assign rsp_word.occupancy   = OCC_W'(count_ff);
   assign rsp_word.is_empty    = stat.cnt_zero;
   assign rsp_word.is_full     = stat.full;

endmodule

/* rtl/pooled_queue_with_keyed_remove_unit.sv */
// enqueue scans for the lowest free slot, one per cycle, then links it at the tail; dequeue
// takes the head; remove walks nodes, one key read per cycle; rejects go to the response
// one word at a time: busy stays high through the strobe cycle, next start is taken after it
// the longest gap between accepted words is set by the free-slot scan of an enqueue
// reset (synchronous) leaves capacity 0 and the pool empty; the receiver cannot stall
module pooled_queue_with_keyed_remove_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pqkr_pkg::req_word_type        req_word,
   output logic                          rsp_strobe,
   output pqkr_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_wr_en,
   input  logic [pqkr_pkg::CAP_BITS-1:0] csr_wr_data
);
   import pqkr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pqkr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_word.action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pqkr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_word    (req_word),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_word    (rsp_word)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("unit still busy after result");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status) |->
         (rsp_word.out_key == '0 && rsp_word.out_payload == '0))
      else $error("failed result carries item data");
`endif

endmodule
